>>> rtl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg: shared definitions for the bitmap frame allocator
// Default sizes, command codes and the types passed between the sequencer
// and the free-bit search unit.
// ----------------------------------------------------------------------------
package bfa_pkg;

    // default geometry of the managed region
    localparam int          BFA_FRAME_CAPACITY = 32768;
    localparam int          BFA_PAGE_BYTES     = 4096;
    localparam logic [31:0] BFA_BASE_ADDRESS   = 32'h0040_0000;

    // one bitmap word covers this many frames
    localparam int BFA_WORD_BITS = 32;
    localparam int BFA_BIT_W     = 5;

    // owner count saturation value
    localparam logic [7:0] BFA_COUNT_MAX = 8'd255;

    // command codes
    typedef enum logic [1:0] {
        CMD_ALLOC  = 2'd0,
        CMD_FREE   = 2'd1,
        CMD_INCREF = 2'd2,
        CMD_QUERY  = 2'd3
    } bfa_cmd_t;

    // search window edges within one bitmap word
    typedef struct packed {
        logic                 lo_here;
        logic [BFA_BIT_W-1:0] lo_bit;
        logic                 hi_here;
        logic [BFA_BIT_W-1:0] hi_bit;
    } bfa_win_t;

    // search result for one bitmap word
    typedef struct packed {
        logic                 found;
        logic [BFA_BIT_W-1:0] pos;
    } bfa_hit_t;

endpackage

>>> rtl/bfa_if.sv
// ----------------------------------------------------------------------------
// bfa_if: channel interfaces of the bitmap frame allocator
// Command, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------

// command channel
interface bfa_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [31:0] address;

    modport source (output valid, output cmd, output address, input ready);
    modport sink   (input valid, input cmd, input address, output ready);
endinterface

// response channel
interface bfa_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] frame_address;
    logic        acted;
    logic [7:0]  owner_count;
    logic [15:0] used_count;
    logic [15:0] total_count;

    modport source (output valid, output frame_address, output acted, output owner_count,
                    output used_count, output total_count, input ready);
    modport sink   (input valid, input frame_address, input acted, input owner_count,
                    input used_count, input total_count, output ready);
endinterface

// configuration write channel
interface bfa_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] memory_bytes;

    modport source (output valid, output memory_bytes, input ready);
    modport sink   (input valid, input memory_bytes, output ready);
endinterface

>>> rtl/bitmap_frame_allocator_refcount.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_refcount: next-fit page frame allocator
// Bitmap of in-use frames plus an 8-bit owner count per frame, with a word
// serial free-frame search under a small sequencer.
// ----------------------------------------------------------------------------
// usage:
//   cfg  : write memory_bytes to install memory; this sets the managed frame
//          count and wipes every frame, the used count and the search hint
//   req  : one command per transaction (alloc, free, add reference, query)
//   rsp  : one result per command, with used and total frame counts
// sequence:
//   free, add reference and query pass through lookup read, update and
//   output load from accept to rsp.valid
//   alloc reads one 32-frame bitmap word per cycle through the search unit;
//   the hint word can be read in both passes
//   one command is in flight at a time; req.ready is high only when idle
// reset and install:
//   after reset and after every cfg write the bitmap is swept to zero, one
//   word per cycle; req.ready stays low meanwhile, cfg.ready is always high
// stall:
//   the result sits in an output register; the next command is accepted
//   while it waits, and that command holds its own result until rsp drains
// ----------------------------------------------------------------------------
module bitmap_frame_allocator_refcount import bfa_pkg::*; #(
    parameter int          FRAME_CAPACITY = BFA_FRAME_CAPACITY,
    parameter int          PAGE_BYTES     = BFA_PAGE_BYTES,
    parameter logic [31:0] BASE_ADDRESS   = BFA_BASE_ADDRESS
) (
    input  logic      clk,
    input  logic      rst_n,
    bfa_cfg_if.sink   cfg,
    bfa_cmd_if.sink   req,
    bfa_rsp_if.source rsp
);

    // derived geometry; PAGE_BYTES is a power of two
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int WORDS      = (FRAME_CAPACITY + BFA_WORD_BITS - 1) / BFA_WORD_BITS;
    localparam int WADDR_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int FRM_W      = WADDR_W + BFA_BIT_W;
    localparam int FW         = FRM_W + 1;
    localparam int IDX_W      = (FRAME_CAPACITY > 1) ? $clog2(FRAME_CAPACITY) : 1;

    localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORDS - 1);
    localparam logic [31:0]        CAP32     = 32'(FRAME_CAPACITY);
    localparam logic [FW-1:0]      CAP_FW    = FW'(FRAME_CAPACITY);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_LOOKUP,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    // sequencer and bookkeeping
    state_t               state_reg,      state_next;
    logic [WADDR_W-1:0]   clr_ptr_reg,    clr_ptr_next;
    logic [FW-1:0]        total_reg,      total_next;
    logic [FW-1:0]        used_reg,       used_next;
    logic [FW-1:0]        hint_reg,       hint_next;
    bfa_cmd_t             cmd_reg,        cmd_next;
    logic [31:0]          addr_reg,       addr_next;

    // scan issue side
    logic [WADDR_W-1:0]   iss_word_reg,   iss_word_next;
    logic                 iss_phase_reg,  iss_phase_next;
    logic                 iss_active_reg, iss_active_next;
    logic [WADDR_W-1:0]   last_a_reg,     last_a_next;
    logic [WADDR_W-1:0]   last_b_reg,     last_b_next;
    logic                 b_nonempty_reg, b_nonempty_next;

    // scan evaluate side
    logic                 ev_valid_reg,   ev_valid_next;
    logic [WADDR_W-1:0]   ev_word_reg,    ev_word_next;
    logic                 ev_phase_reg,   ev_phase_next;
    logic                 ev_last_reg,    ev_last_next;

    // single-frame lookup
    logic                 in_range_reg,   in_range_next;
    logic [FRM_W-1:0]     idx_reg,        idx_next;

    // result staging and output register
    logic [31:0]          res_addr_reg,   res_addr_next;
    logic                 res_acted_reg,  res_acted_next;
    logic [7:0]           res_owner_reg,  res_owner_next;
    logic                 rsp_valid_reg,  rsp_valid_next;
    logic [31:0]          out_addr_reg,   out_addr_next;
    logic                 out_acted_reg,  out_acted_next;
    logic [7:0]           out_owner_reg,  out_owner_next;
    logic [15:0]          out_used_reg,   out_used_next;
    logic [15:0]          out_total_reg,  out_total_next;

    // memories and their ports
    logic [BFA_WORD_BITS-1:0] bitmap_mem [WORDS];
    logic [7:0]               count_mem  [FRAME_CAPACITY];
    logic [BFA_WORD_BITS-1:0] bm_rd_reg;
    logic [7:0]               cnt_rd_reg;
    logic                     bm_re, bm_we, cnt_re, cnt_we;
    logic [WADDR_W-1:0]       bm_raddr, bm_waddr;
    logic [BFA_WORD_BITS-1:0] bm_wdata;
    logic [IDX_W-1:0]         cnt_raddr, cnt_waddr;
    logic [7:0]               cnt_wdata;

    // combinational helpers
    logic [31:0]          cfg_diff, cfg_frames;
    logic [FW-1:0]        cfg_total;
    logic [31:0]          loc_off, loc_idx32;
    logic                 loc_hit;
    logic [FRM_W-1:0]     loc_frame;
    logic [FW-1:0]        total_m1, hint_m1;
    logic [FW-1:0]        win_lo, win_hi;
    bfa_win_t             win;
    bfa_hit_t             hit;
    logic [FRM_W-1:0]     found_frame;
    logic [BFA_WORD_BITS-1:0] found_mask;
    logic                 iss_end;
    logic                 cur_bit;
    logic                 slot_free;

    // install: frame count from memory size, capped at capacity
    always_comb
    begin
        cfg_diff   = cfg.memory_bytes - BASE_ADDRESS;
        cfg_frames = cfg_diff >> PAGE_SHIFT;
        if (cfg.memory_bytes <= BASE_ADDRESS)
        begin
            cfg_total = '0;
        end
        else if (cfg_frames > CAP32)
        begin
            cfg_total = CAP_FW;
        end
        else
        begin
            cfg_total = cfg_frames[FW-1:0];
        end
    end

    // address to frame index and range check
    always_comb
    begin
        loc_off   = addr_reg - BASE_ADDRESS;
        loc_idx32 = loc_off >> PAGE_SHIFT;
        loc_hit   = (addr_reg >= BASE_ADDRESS) && (loc_idx32 < 32'(total_reg));
        loc_frame = loc_idx32[FRM_W-1:0];
        total_m1  = total_reg - FW'(1);
        hint_m1   = hint_reg - FW'(1);
    end

    // search window of the word being evaluated
    always_comb
    begin
        win_lo      = ev_phase_reg ? '0 : hint_reg;
        win_hi      = ev_phase_reg ? hint_reg : total_reg;
        win.lo_here = !ev_phase_reg && ({1'b0, ev_word_reg} == win_lo[FW-1:BFA_BIT_W]);
        win.lo_bit  = win_lo[BFA_BIT_W-1:0];
        win.hi_here = ({1'b0, ev_word_reg} == win_hi[FW-1:BFA_BIT_W]);
        win.hi_bit  = win_hi[BFA_BIT_W-1:0];
    end

    // free-bit search unit
    bfa_ffz u_ffz (
        .word_bits (bm_rd_reg),
        .win       (win),
        .hit       (hit)
    );

    always_comb
    begin
        found_frame = {ev_word_reg, hit.pos};
        found_mask  = BFA_WORD_BITS'(1) << hit.pos;
        iss_end     = iss_word_reg == (iss_phase_reg ? last_b_reg : last_a_reg);
        cur_bit     = bm_rd_reg[idx_reg[BFA_BIT_W-1:0]];
        slot_free   = !rsp_valid_reg || rsp.ready;
    end

    // sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        clr_ptr_next    = clr_ptr_reg;
        total_next      = total_reg;
        used_next       = used_reg;
        hint_next       = hint_reg;
        cmd_next        = cmd_reg;
        addr_next       = addr_reg;
        iss_word_next   = iss_word_reg;
        iss_phase_next  = iss_phase_reg;
        iss_active_next = iss_active_reg;
        last_a_next     = last_a_reg;
        last_b_next     = last_b_reg;
        b_nonempty_next = b_nonempty_reg;
        ev_valid_next   = 1'b0;
        ev_word_next    = ev_word_reg;
        ev_phase_next   = ev_phase_reg;
        ev_last_next    = ev_last_reg;
        in_range_next   = in_range_reg;
        idx_next        = idx_reg;
        res_addr_next   = res_addr_reg;
        res_acted_next  = res_acted_reg;
        res_owner_next  = res_owner_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        out_addr_next   = out_addr_reg;
        out_acted_next  = out_acted_reg;
        out_owner_next  = out_owner_reg;
        out_used_next   = out_used_reg;
        out_total_next  = out_total_reg;

        bm_re     = 1'b0;
        bm_raddr  = iss_word_reg;
        bm_we     = 1'b0;
        bm_waddr  = clr_ptr_reg;
        bm_wdata  = '0;
        cnt_re    = 1'b0;
        cnt_raddr = loc_frame[IDX_W-1:0];
        cnt_we    = 1'b0;
        cnt_waddr = idx_reg[IDX_W-1:0];
        cnt_wdata = '0;

        unique case (state_reg)
            // sweep the bitmap to all free
            ST_CLEAR:
            begin
                bm_we    = 1'b1;
                bm_waddr = clr_ptr_reg;
                if (clr_ptr_reg == LAST_WORD)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_ptr_next = clr_ptr_reg + WADDR_W'(1);
                end
            end

            // take a command
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next       = bfa_cmd_t'(req.cmd);
                    addr_next      = req.address;
                    res_addr_next  = '0;
                    res_acted_next = 1'b0;
                    res_owner_next = '0;
                    if (bfa_cmd_t'(req.cmd) != CMD_ALLOC)
                    begin
                        state_next = ST_LOOKUP;
                    end
                    else if (total_reg == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        // hint up to end first, then wrap from frame 0 up to hint
                        state_next      = ST_SCAN;
                        iss_active_next = 1'b1;
                        last_a_next     = total_m1[FRM_W-1:BFA_BIT_W];
                        last_b_next     = hint_m1[FRM_W-1:BFA_BIT_W];
                        b_nonempty_next = hint_reg != '0;
                        if (hint_reg != total_reg)
                        begin
                            iss_phase_next = 1'b0;
                            iss_word_next  = hint_reg[FRM_W-1:BFA_BIT_W];
                        end
                        else
                        begin
                            iss_phase_next = 1'b1;
                            iss_word_next  = '0;
                        end
                    end
                end
            end

            // one word read per cycle, evaluated the cycle after
            ST_SCAN:
            begin
                if (iss_active_reg)
                begin
                    bm_re         = 1'b1;
                    bm_raddr      = iss_word_reg;
                    ev_valid_next = 1'b1;
                    ev_word_next  = iss_word_reg;
                    ev_phase_next = iss_phase_reg;
                    ev_last_next  = iss_end && (iss_phase_reg || !b_nonempty_reg);
                    if (iss_end)
                    begin
                        if (!iss_phase_reg && b_nonempty_reg)
                        begin
                            iss_phase_next = 1'b1;
                            iss_word_next  = '0;
                        end
                        else
                        begin
                            iss_active_next = 1'b0;
                        end
                    end
                    else
                    begin
                        iss_word_next = iss_word_reg + WADDR_W'(1);
                    end
                end
                if (ev_valid_reg && hit.found)
                begin
                    bm_we           = 1'b1;
                    bm_waddr        = ev_word_reg;
                    bm_wdata        = bm_rd_reg | found_mask;
                    cnt_we          = 1'b1;
                    cnt_waddr       = found_frame[IDX_W-1:0];
                    cnt_wdata       = 8'd1;
                    used_next       = used_reg + FW'(1);
                    hint_next       = FW'(found_frame) + FW'(1);
                    res_addr_next   = BASE_ADDRESS + (32'(found_frame) << PAGE_SHIFT);
                    res_acted_next  = 1'b1;
                    iss_active_next = 1'b0;
                    ev_valid_next   = 1'b0;
                    state_next      = ST_FINISH;
                end
                else if (ev_valid_reg && ev_last_reg)
                begin
                    iss_active_next = 1'b0;
                    ev_valid_next   = 1'b0;
                    state_next      = ST_FINISH;
                end
            end

            // read bitmap word and owner count of the addressed frame
            ST_LOOKUP:
            begin
                bm_re         = 1'b1;
                bm_raddr      = loc_frame[FRM_W-1:BFA_BIT_W];
                cnt_re        = 1'b1;
                cnt_raddr     = loc_frame[IDX_W-1:0];
                in_range_next = loc_hit;
                idx_next      = loc_frame;
                state_next    = ST_UPDATE;
            end

            // free, add reference or query on the looked-up frame
            ST_UPDATE:
            begin
                state_next = ST_FINISH;
                unique case (cmd_reg)
                    CMD_FREE:
                    begin
                        if (in_range_reg && cur_bit)
                        begin
                            res_acted_next = 1'b1;
                            cnt_we         = 1'b1;
                            if (cnt_rd_reg > 8'd1)
                            begin
                                cnt_wdata = cnt_rd_reg - 8'd1;
                            end
                            else
                            begin
                                cnt_wdata = '0;
                                bm_we     = 1'b1;
                                bm_waddr  = idx_reg[FRM_W-1:BFA_BIT_W];
                                bm_wdata  = bm_rd_reg &
                                            ~(BFA_WORD_BITS'(1) << idx_reg[BFA_BIT_W-1:0]);
                                if (used_reg != '0)
                                begin
                                    used_next = used_reg - FW'(1);
                                end
                                if (FW'(idx_reg) < hint_reg)
                                begin
                                    hint_next = FW'(idx_reg);
                                end
                            end
                        end
                    end
                    CMD_INCREF:
                    begin
                        if (in_range_reg && cur_bit && cnt_rd_reg != BFA_COUNT_MAX)
                        begin
                            res_acted_next = 1'b1;
                            cnt_we         = 1'b1;
                            cnt_wdata      = cnt_rd_reg + 8'd1;
                        end
                    end
                    CMD_QUERY:
                    begin
                        if (in_range_reg)
                        begin
                            res_acted_next = 1'b1;
                            res_owner_next = cur_bit ? cnt_rd_reg : 8'd0;
                        end
                    end
                    CMD_ALLOC:
                    begin
                        res_acted_next = res_acted_reg;
                    end
                endcase
            end

            // hand the result to the output register once it is free
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    out_addr_next  = res_addr_reg;
                    out_acted_next = res_acted_reg;
                    out_owner_next = res_owner_reg;
                    out_used_next  = 16'(used_reg);
                    out_total_next = 16'(total_reg);
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // install wipes everything and restarts the sweep
        if (cfg.valid)
        begin
            state_next      = ST_CLEAR;
            clr_ptr_next    = '0;
            total_next      = cfg_total;
            used_next       = '0;
            hint_next       = '0;
            iss_active_next = 1'b0;
            ev_valid_next   = 1'b0;
        end
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_ptr_reg    <= '0;
            total_reg      <= '0;
            used_reg       <= '0;
            hint_reg       <= '0;
            cmd_reg        <= CMD_ALLOC;
            addr_reg       <= '0;
            iss_word_reg   <= '0;
            iss_phase_reg  <= 1'b0;
            iss_active_reg <= 1'b0;
            last_a_reg     <= '0;
            last_b_reg     <= '0;
            b_nonempty_reg <= 1'b0;
            ev_valid_reg   <= 1'b0;
            ev_word_reg    <= '0;
            ev_phase_reg   <= 1'b0;
            ev_last_reg    <= 1'b0;
            in_range_reg   <= 1'b0;
            idx_reg        <= '0;
            res_addr_reg   <= '0;
            res_acted_reg  <= 1'b0;
            res_owner_reg  <= '0;
            rsp_valid_reg  <= 1'b0;
            out_addr_reg   <= '0;
            out_acted_reg  <= 1'b0;
            out_owner_reg  <= '0;
            out_used_reg   <= '0;
            out_total_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_ptr_reg    <= clr_ptr_next;
            total_reg      <= total_next;
            used_reg       <= used_next;
            hint_reg       <= hint_next;
            cmd_reg        <= cmd_next;
            addr_reg       <= addr_next;
            iss_word_reg   <= iss_word_next;
            iss_phase_reg  <= iss_phase_next;
            iss_active_reg <= iss_active_next;
            last_a_reg     <= last_a_next;
            last_b_reg     <= last_b_next;
            b_nonempty_reg <= b_nonempty_next;
            ev_valid_reg   <= ev_valid_next;
            ev_word_reg    <= ev_word_next;
            ev_phase_reg   <= ev_phase_next;
            ev_last_reg    <= ev_last_next;
            in_range_reg   <= in_range_next;
            idx_reg        <= idx_next;
            res_addr_reg   <= res_addr_next;
            res_acted_reg  <= res_acted_next;
            res_owner_reg  <= res_owner_next;
            rsp_valid_reg  <= rsp_valid_next;
            out_addr_reg   <= out_addr_next;
            out_acted_reg  <= out_acted_next;
            out_owner_reg  <= out_owner_next;
            out_used_reg   <= out_used_next;
            out_total_reg  <= out_total_next;
        end
    end

    // in-use bitmap, one 32-frame word per entry
    always_ff @(posedge clk)
    begin
        if (bm_we)
        begin
            bitmap_mem[bm_waddr] <= bm_wdata;
        end
        if (bm_re)
        begin
            bm_rd_reg <= bitmap_mem[bm_raddr];
        end
    end

    // owner counts, meaningful only while the frame's bit is set
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            count_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re)
        begin
            cnt_rd_reg <= count_mem[cnt_raddr];
        end
    end

    // channel ports
    assign cfg.ready         = 1'b1;
    assign req.ready         = (state_reg == ST_IDLE);
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.frame_address = out_addr_reg;
    assign rsp.acted         = out_acted_reg;
    assign rsp.owner_count   = out_owner_reg;
    assign rsp.used_count    = out_used_reg;
    assign rsp.total_count   = out_total_reg;

`ifndef SYNTH
    // never more frames in use than managed
    assert property (@(posedge clk) disable iff (!rst_n) used_reg <= total_reg)
        else $error("used frame count exceeds total");

    // next-fit hint stays within the managed range
    assert property (@(posedge clk) disable iff (!rst_n) hint_reg <= total_reg)
        else $error("search hint beyond total frames");

    // an allocation sets exactly one bit that was free
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && bm_we) |->
        ($countones(bm_wdata) == $countones(bm_rd_reg) + 1))
        else $error("allocation did not take exactly one free frame");

    // a finished command reaches the output in the next cycle when the output register is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && !rsp_valid_reg && !cfg.valid) |=> rsp_valid_reg)
        else $error("result not loaded into free output register");
`endif

endmodule

>>> rtl/bfa_ffz.sv
// ----------------------------------------------------------------------------
// bfa_ffz: free-bit search over one bitmap word
// Masks the word to the search window and returns the lowest free frame bit.
// ----------------------------------------------------------------------------
module bfa_ffz import bfa_pkg::*; (
    input  logic [BFA_WORD_BITS-1:0] word_bits,
    input  bfa_win_t                 win,
    output bfa_hit_t                 hit
);

    logic [BFA_WORD_BITS-1:0] ones;
    logic [BFA_WORD_BITS-1:0] lo_mask;
    logic [BFA_WORD_BITS-1:0] hi_mask;
    logic [BFA_WORD_BITS-1:0] cand;

    // window masks: bits at or above the low edge, below the high edge
    always_comb
    begin
        ones    = '1;
        lo_mask = win.lo_here ? (ones << win.lo_bit) : ones;
        hi_mask = win.hi_here ? ~(ones << win.hi_bit) : ones;
        cand    = ~word_bits & lo_mask & hi_mask;
    end

    // lowest set candidate bit
    always_comb
    begin
        hit.found = |cand;
        hit.pos   = '0;
        for (int i = BFA_WORD_BITS - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                hit.pos = BFA_BIT_W'(i);
            end
        end
    end

endmodule

>>> sim/bfa_checker.sv
// ----------------------------------------------------------------------------
// bfa_checker: response checker for the bitmap frame allocator
// Watches the configuration, command and response channels. Keeps its own
// copy of the frame bitmap, owner counts, used count and next-fit hint, works
// out the response to every accepted command and compares each delivered
// response field by field, in order.
// ----------------------------------------------------------------------------
module bfa_checker import bfa_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    bfa_cfg_if   cfg,
    bfa_cmd_if   req,
    bfa_rsp_if   rsp,
    output int   mismatches,
    output int   outstanding
);

    typedef struct {
        logic [31:0] frame_address;
        logic        acted;
        logic [7:0]  owner_count;
        logic [15:0] used_count;
        logic [15:0] total_count;
    } frame_result_t;

    // allocator state as seen from outside
    bit          in_use [BFA_FRAME_CAPACITY];
    logic [7:0]  owners [BFA_FRAME_CAPACITY];
    int unsigned taken_frames;
    int unsigned scan_start;
    int unsigned managed_frames;

    frame_result_t results_due [$];

    // install wipes every frame and derives the managed frame count
    function automatic void install_memory(input logic [31:0] bytes);
        logic [31:0] frames;
        for (int i = 0; i < BFA_FRAME_CAPACITY; i++)
        begin
            in_use[i] = 1'b0;
            owners[i] = 8'd0;
        end
        taken_frames = 0;
        scan_start   = 0;
        if (bytes <= BFA_BASE_ADDRESS)
        begin
            managed_frames = 0;
        end
        else
        begin
            frames = (bytes - BFA_BASE_ADDRESS) / 32'(BFA_PAGE_BYTES);
            managed_frames = (frames > 32'(BFA_FRAME_CAPACITY)) ? BFA_FRAME_CAPACITY : frames;
        end
    endfunction

    // address to frame index, only for managed frames
    function automatic bit frame_of(input logic [31:0] address, output int unsigned idx);
        logic [31:0] offs;
        idx = 0;
        if (address < BFA_BASE_ADDRESS)
            return 1'b0;
        offs = (address - BFA_BASE_ADDRESS) / 32'(BFA_PAGE_BYTES);
        if (offs >= managed_frames)
            return 1'b0;
        idx = offs;
        return 1'b1;
    endfunction

    // claim the first free frame in [lo, hi)
    function automatic bit claim_first_free(input int unsigned lo, input int unsigned hi,
                                            output logic [31:0] addr);
        addr = 32'd0;
        for (int unsigned i = lo; i < hi; i++)
        begin
            if (!in_use[i])
            begin
                in_use[i]    = 1'b1;
                owners[i]    = 8'd1;
                taken_frames = taken_frames + 1;
                scan_start   = i + 1;
                addr         = BFA_BASE_ADDRESS + 32'(i) * 32'(BFA_PAGE_BYTES);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // apply one command and return the response it owes
    function automatic frame_result_t run_command(input bfa_cmd_t op,
                                                  input logic [31:0] address);
        frame_result_t r;
        int unsigned   idx;
        int unsigned   hint_now;
        logic [31:0]   addr;
        bit            hit;
        r.frame_address = 32'd0;
        r.acted         = 1'b0;
        r.owner_count   = 8'd0;
        hint_now        = scan_start;
        case (op)
            CMD_ALLOC:
            begin
                if (managed_frames != 0)
                begin
                    // next fit: hint to end, then wrap from frame 0 to the hint
                    hit = claim_first_free(hint_now, managed_frames, addr);
                    if (!hit)
                        hit = claim_first_free(0, hint_now, addr);
                    r.acted         = hit;
                    r.frame_address = addr;
                end
            end
            CMD_FREE:
            begin
                hit = frame_of(address, idx);
                if (hit && in_use[idx])
                begin
                    r.acted = 1'b1;
                    if (owners[idx] > 8'd1)
                    begin
                        owners[idx] = owners[idx] - 8'd1;
                    end
                    else
                    begin
                        owners[idx] = 8'd0;
                        in_use[idx] = 1'b0;
                        if (taken_frames > 0)
                            taken_frames = taken_frames - 1;
                        if (idx < scan_start)
                            scan_start = idx;
                    end
                end
            end
            CMD_INCREF:
            begin
                hit = frame_of(address, idx);
                if (hit && in_use[idx] && owners[idx] < BFA_COUNT_MAX)
                begin
                    owners[idx] = owners[idx] + 8'd1;
                    r.acted     = 1'b1;
                end
            end
            default:
            begin
                hit = frame_of(address, idx);
                if (hit)
                begin
                    r.owner_count = owners[idx];
                    r.acted       = 1'b1;
                end
            end
        endcase
        r.used_count  = 16'(taken_frames);
        r.total_count = 16'(managed_frames);
        return r;
    endfunction

    // one line per mismatch
    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        mismatches = mismatches + 1;
        $display("mismatch on %s: got %0h, expected %0h (t=%0t)", what, got, want, $time);
    endtask

    initial begin
        mismatches  = 0;
        outstanding = 0;
        install_memory(32'd0);
    end

    // channel monitor: response first, then config, then new command
    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n)
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (results_due.size() == 0)
                begin
                    report("unexpected response", rsp.frame_address, 32'd0);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (rsp.frame_address !== want.frame_address)
                        report("frame_address", rsp.frame_address, want.frame_address);
                    if (rsp.acted !== want.acted)
                        report("acted", 32'(rsp.acted), 32'(want.acted));
                    if (rsp.owner_count !== want.owner_count)
                        report("owner_count", 32'(rsp.owner_count), 32'(want.owner_count));
                    if (rsp.used_count !== want.used_count)
                        report("used_count", 32'(rsp.used_count), 32'(want.used_count));
                    if (rsp.total_count !== want.total_count)
                        report("total_count", 32'(rsp.total_count), 32'(want.total_count));
                end
            end
            if (cfg.valid && cfg.ready)
                install_memory(cfg.memory_bytes);
            if (req.valid && req.ready)
                results_due.push_back(run_command(bfa_cmd_t'(req.cmd), req.address));
        end
        outstanding <= results_due.size();
    end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for the bitmap frame allocator
// Drives installs and commands with random gaps and response back-pressure:
// a directed opening over empty, one-frame and capped memory, owner count
// saturation, then random command mixes over several memory sizes.
// ----------------------------------------------------------------------------
module tb import bfa_pkg::*; ();

    localparam int unsigned CYCLE_LIMIT = 5_000_000;
    localparam logic [31:0] PAGE        = 32'(BFA_PAGE_BYTES);
    localparam logic [31:0] BASE        = BFA_BASE_ADDRESS;

    // memory sizes and command counts of the random phases
    localparam logic [31:0] PHASE_BYTES [8] = '{
        BASE + 33 * PAGE, BASE, BASE + 40 * PAGE + 32'd100, 32'hFFFF_FFFF,
        BASE + PAGE - 32'd1, BASE + 32 * PAGE, BASE + 3 * PAGE, 32'h0840_0000
    };
    localparam int PHASE_ITEMS [8] = '{50, 15, 60, 25, 15, 50, 60, 25};

    logic        clk = 1'b0;
    logic        rst_n;
    logic        calm;
    int          mismatches;
    int          outstanding;
    int unsigned cycles = 0;
    int unsigned cur_frames;

    bfa_cfg_if cfg ();
    bfa_cmd_if req ();
    bfa_rsp_if rsp ();

    bitmap_frame_allocator_refcount dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .rsp   (rsp)
    );

    bfa_checker watch (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .req         (req),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #4 clk = ~clk;

    // response back-pressure
    always @(posedge clk)
    begin
        rsp.ready <= calm || ($urandom_range(99, 0) >= 26);
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // send one command transaction, with a random gap first
    task automatic issue(input bfa_cmd_t op, input logic [31:0] address);
        while (!calm && $urandom_range(99, 0) < 26)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid   <= 1'b1;
        req.cmd     <= op;
        req.address <= address;
        do @(posedge clk); while (!req.ready);
    endtask

    // wait until every response is back
    task automatic drain();
        req.valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        @(posedge clk);
    endtask

    // install memory once the allocator is idle
    task automatic install(input logic [31:0] bytes);
        drain();
        cfg.valid        <= 1'b1;
        cfg.memory_bytes <= bytes;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (bytes <= BASE)
            cur_frames = 0;
        else if ((bytes - BASE) / PAGE > 32'(BFA_FRAME_CAPACITY))
            cur_frames = BFA_FRAME_CAPACITY;
        else
            cur_frames = (bytes - BASE) / PAGE;
    endtask

    // weighted toward allocation so memory fills up
    function automatic bfa_cmd_t pick_command();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 40)
            return CMD_ALLOC;
        if (r < 67)
            return CMD_FREE;
        if (r < 82)
            return CMD_INCREF;
        return CMD_QUERY;
    endfunction

    // mostly managed frames near the bottom, some below base or past the end
    function automatic logic [31:0] pick_address();
        int unsigned r;
        int unsigned idx;
        r = $urandom_range(99, 0);
        if (r < 8)
            return $urandom();
        if (r < 13)
            return $urandom_range(BASE - 32'd1, 0);
        if (r < 18)
            idx = cur_frames + $urandom_range(3, 0);
        else if (cur_frames == 0)
            idx = 0;
        else if (r < 22)
            idx = cur_frames - 1;
        else if (cur_frames > 64)
            idx = $urandom_range(63, 0);
        else
            idx = $urandom_range(cur_frames - 1, 0);
        return BASE + 32'(idx) * PAGE + $urandom_range(PAGE - 32'd1, 0);
    endfunction

    initial
    begin
        rst_n            = 1'b0;
        calm             = 1'b0;
        cur_frames       = 0;
        req.valid        = 1'b0;
        req.cmd          = CMD_ALLOC;
        req.address      = 32'd0;
        cfg.valid        = 1'b0;
        cfg.memory_bytes = 32'd0;
        rsp.ready        = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // nothing installed: no frames at all
        issue(CMD_ALLOC, 32'd0);
        issue(CMD_QUERY, BASE);
        issue(CMD_FREE, BASE);
        issue(CMD_INCREF, 32'hFFFF_FFFF);
        install(32'd0);
        issue(CMD_ALLOC, 32'd0);

        // one frame: full memory, sharing, double free, range edges
        install(BASE + PAGE);
        issue(CMD_ALLOC, 32'd0);
        issue(CMD_ALLOC, 32'd0);
        issue(CMD_QUERY, BASE + PAGE - 32'd1);
        issue(CMD_INCREF, BASE);
        issue(CMD_FREE, BASE);
        issue(CMD_FREE, BASE);
        issue(CMD_FREE, BASE);
        issue(CMD_INCREF, BASE);
        issue(CMD_QUERY, BASE);
        issue(CMD_QUERY, BASE + PAGE);
        issue(CMD_FREE, BASE - 32'd1);
        issue(CMD_QUERY, 32'd0);

        // owner count saturation
        issue(CMD_ALLOC, 32'd0);
        repeat (255) issue(CMD_INCREF, BASE + $urandom_range(PAGE - 32'd1, 0));
        issue(CMD_QUERY, BASE);
        issue(CMD_FREE, BASE);

        // capped memory: hint lowered by a free, last frame and one past it
        install(32'hFFFF_FFFF);
        repeat (3) issue(CMD_ALLOC, 32'd0);
        issue(CMD_FREE, BASE + PAGE);
        issue(CMD_ALLOC, 32'd0);
        issue(CMD_QUERY, BASE + 32'(BFA_FRAME_CAPACITY - 1) * PAGE);
        issue(CMD_QUERY, BASE + 32'(BFA_FRAME_CAPACITY) * PAGE);

        // random phases over several memory sizes, one without idling
        for (int p = 0; p < 8; p++)
        begin
            install(PHASE_BYTES[p]);
            calm <= (p == 2);
            for (int n = 0; n < PHASE_ITEMS[p]; n++)
                issue(pick_command(), pick_address());
        end

        drain();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
